// ===== rtl/hngen_pkg.sv =====
// Shared constants for the height-map normal generator.
// Register indexes, request kinds and fixed-point widths; no dependencies.
package hngen_pkg;

  localparam logic [1:0] REG_GRID_SIZE = 2'd0;
  localparam logic [1:0] REG_SCALE_X   = 2'd1;
  localparam logic [1:0] REG_SCALE_Y   = 2'd2;
  localparam logic [1:0] REG_SCALE_Z   = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OOB = 1'b1;

  localparam int QW = 15;                       // magnitude of a Q2.14 component
  localparam logic [QW-1:0] ONE_Q14 = 15'd16384;
  localparam int NW = 25;                       // |n_i|
  localparam int SW = 52;                       // |n|^2
  localparam int KW = 30;                       // (2t-1)^2
  localparam int LW = 82;                       // compare width

endpackage

// ===== rtl/hngen_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module hngen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/heightmap_normal_generator_unit.sv =====
// Height-map normal generator top level: height store, sequencer and one
// shared 32x32 multiplier. Uses hngen_pkg and hngen_ram.
//
// Input beats: in_tuser = request kind (0 write, 1 query), in_tdata holds
// col, row and height. A write in the grid stores its height and gives no
// result. A query gives one output beat: the unit normal in signed Q2.14
// on out_tdata and out_tuser = status (1 when col or row is outside the
// grid, normal then zero).
// A query in the grid runs the height reads, eight multiplier steps for the
// vector and its squared length, then per component one square and fifteen
// bit decisions, each of k*k, two partial products and compare, or only k*k
// and compare when the candidate exceeds one. An out-of-grid query goes
// straight to the output step. in_tready is low while a query is
// at work. A finished result waits in the output register while out_tready
// is low; the next query then holds at its final step until the register
// frees. Reset clears control and sets the registers to grid 128, scales 1;
// the height store is not cleared and must be written before it is read.
// cfg_* writes take effect at once and must only come while the block is idle.
module heightmap_normal_generator_unit #(
  parameter int MAX_SIDE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // col[6:0], row[13:7], height[21:14], zero pad
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  output logic        out_tuser   // status
);

  localparam int CLG = $clog2(MAX_SIDE + 1);
  localparam int CW  = (CLG > 8) ? CLG : 8;
  localparam int AW  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int QW  = hngen_pkg::QW;
  localparam int NW  = hngen_pkg::NW;
  localparam int SW  = hngen_pkg::SW;
  localparam int KW  = hngen_pkg::KW;
  localparam int LW  = hngen_pkg::LW;
  localparam int HS  = SW / 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_SQ   = 4'd3;
  localparam logic [3:0] ST_KK   = 4'd4;
  localparam logic [3:0] ST_PL   = 4'd5;
  localparam logic [3:0] ST_PH   = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    grid_r, sclx_r, scly_r, sclz_r;
  logic [CW-1:0] x_r, z_r, xw_r, xe_r, zs_r, zn_r;
  logic [CW-1:0] x_nxt, z_nxt, xw_nxt, xe_nxt, zs_nxt, zn_nxt;
  logic          dx2_r, dz2_r, dx2_nxt, dz2_nxt;
  logic          err_r, err_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [7:0]    hw_r, he_r, hs_r, hn_r, hw_nxt, he_nxt, hs_nxt, hn_nxt;
  logic [15:0]   bm_r, dm_r, bm_nxt, dm_nxt;
  logic [17:0]   ae_r, ae_nxt;
  logic [NW-1:0] n0_r, n1_r, n2_r, n0_nxt, n1_nxt, n2_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [49:0]   mm_r, mm_nxt;
  logic [KW-1:0] kk_r, kk_nxt;
  logic [55:0]   pl_r, ph_r, pl_nxt, ph_nxt;
  logic [QW-1:0] t_r, t_nxt, r0_r, r1_r, r2_r, r0_nxt, r1_nxt, r2_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;
  logic          out_user_r, out_user_nxt;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [CW-1:0] grid_ext, side, col_ext, row_ext;
  logic          in_grid, accept;
  logic [7:0]    sx, sy, sz, dfx, dfz;
  logic [8:0]    a_val, e_val;
  logic          negx, negz;
  logic [QW-1:0] cand;
  logic [15:0]   kval;
  logic [LW-1:0] lhs, rhs;
  logic [NW-1:0] m_sel;
  logic          ram_we;
  logic [CW-1:0] rd_x, rd_z, ram_x, ram_z;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_q;
  logic [15:0]   fx, fy, fz;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign grid_ext = CW'(grid_r);
  assign side = (grid_ext < CW'(2)) ? CW'(2) :
                (grid_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : grid_ext;
  assign col_ext = CW'(in_tdata[6:0]);
  assign row_ext = CW'(in_tdata[13:7]);
  assign in_grid = (col_ext < side) && (row_ext < side);
  assign in_tready = (state_r == ST_IDLE);
  assign accept = in_tvalid && in_tready;

  assign sx = (sclx_r == 8'd0) ? 8'd1 : sclx_r;
  assign sy = (scly_r == 8'd0) ? 8'd1 : scly_r;
  assign sz = (sclz_r == 8'd0) ? 8'd1 : sclz_r;
  assign a_val = dx2_r ? {sx, 1'b0} : {1'b0, sx};
  assign e_val = dz2_r ? {sz, 1'b0} : {1'b0, sz};
  assign negx = he_r > hw_r;
  assign negz = hn_r > hs_r;
  assign dfx = negx ? (he_r - hw_r) : (hw_r - he_r);
  assign dfz = negz ? (hn_r - hs_r) : (hs_r - hn_r);

  assign cand = t_r | (QW'(1) << bit_r);
  assign kval = {cand, 1'b0} - 16'd1;
  assign lhs = {ph_r, 26'd0} + LW'(pl_r);
  assign rhs = {mm_r, 30'd0} + LW'(0);

  always_comb begin
    case (comp_r)
      2'd0:    m_sel = n0_r;
      2'd1:    m_sel = n1_r;
      default: m_sel = n2_r;
    endcase
  end

  always_comb begin
    case (cnt_r)
      3'd0:    begin rd_x = xw_r; rd_z = z_r;  end
      3'd1:    begin rd_x = xe_r; rd_z = z_r;  end
      3'd2:    begin rd_x = x_r;  rd_z = zs_r; end
      default: begin rd_x = x_r;  rd_z = zn_r; end
    endcase
  end

  assign ram_we = accept && (in_tuser == hngen_pkg::REQ_WRITE) && in_grid;
  assign ram_x = (state_r == ST_IDLE) ? col_ext : rd_x;
  assign ram_z = (state_r == ST_IDLE) ? row_ext : rd_z;
  assign ram_addr = AW'(ram_z) * AW'(MAX_SIDE) + AW'(ram_x);

  hngen_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SIDE * MAX_SIDE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[21:14]),
    .rdata (ram_q)
  );

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      ST_MUL: begin
        case (cnt_r)
          3'd0:    begin mul_a = 32'(dfx);  mul_b = 32'(sy);    end
          3'd1:    begin mul_a = 32'(dfz);  mul_b = 32'(sy);    end
          3'd2:    begin mul_a = 32'(a_val); mul_b = 32'(e_val); end
          3'd3:    begin mul_a = 32'(bm_r); mul_b = 32'(e_val); end
          3'd4:    begin mul_a = 32'(a_val); mul_b = 32'(dm_r);  end
          3'd5:    begin mul_a = 32'(n0_r); mul_b = 32'(n0_r);  end
          3'd6:    begin mul_a = 32'(n1_r); mul_b = 32'(n1_r);  end
          default: begin mul_a = 32'(n2_r); mul_b = 32'(n2_r);  end
        endcase
      end
      ST_SQ:   begin mul_a = 32'(m_sel); mul_b = 32'(m_sel); end
      ST_KK:   begin mul_a = 32'(kval);  mul_b = 32'(kval);  end
      ST_PL:   begin mul_a = 32'(kk_r);  mul_b = 32'(s_r[HS-1:0]); end
      ST_PH:   begin mul_a = 32'(kk_r);  mul_b = 32'(s_r[SW-1:HS]); end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; z_nxt = z_r; xw_nxt = xw_r; xe_nxt = xe_r; zs_nxt = zs_r; zn_nxt = zn_r;
    dx2_nxt = dx2_r; dz2_nxt = dz2_r; err_nxt = err_r; cnt_nxt = cnt_r;
    hw_nxt = hw_r; he_nxt = he_r; hs_nxt = hs_r; hn_nxt = hn_r;
    bm_nxt = bm_r; dm_nxt = dm_r; ae_nxt = ae_r;
    n0_nxt = n0_r; n1_nxt = n1_r; n2_nxt = n2_r; s_nxt = s_r; mm_nxt = mm_r;
    kk_nxt = kk_r; pl_nxt = pl_r; ph_nxt = ph_r; t_nxt = t_r; bit_nxt = bit_r;
    r0_nxt = r0_r; r1_nxt = r1_r; r2_nxt = r2_r; comp_nxt = comp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r; out_user_nxt = out_user_r;
    fx = err_r ? 16'd0 : (negx ? 16'd0 - 16'(r0_r) : 16'(r0_r));
    fy = err_r ? 16'd0 : 16'(r1_r);
    fz = err_r ? 16'd0 : (negz ? 16'd0 - 16'(r2_r) : 16'(r2_r));
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_tuser == hngen_pkg::REQ_QUERY)) begin
          x_nxt = col_ext;
          z_nxt = row_ext;
          xw_nxt = (col_ext > CW'(0)) ? col_ext - CW'(1) : col_ext;
          xe_nxt = (col_ext < side - CW'(1)) ? col_ext + CW'(1) : col_ext;
          zs_nxt = (row_ext > CW'(0)) ? row_ext - CW'(1) : row_ext;
          zn_nxt = (row_ext < side - CW'(1)) ? row_ext + CW'(1) : row_ext;
          dx2_nxt = (col_ext > CW'(0)) && (col_ext < side - CW'(1));
          dz2_nxt = (row_ext > CW'(0)) && (row_ext < side - CW'(1));
          err_nxt = !in_grid;
          cnt_nxt = 3'd0;
          state_nxt = in_grid ? ST_RD : ST_OUT;
        end
      end
      ST_RD: begin
        case (cnt_r)
          3'd1:    hw_nxt = ram_q;
          3'd2:    he_nxt = ram_q;
          3'd3:    hs_nxt = ram_q;
          3'd4:    hn_nxt = ram_q;
          default: ;
        endcase
        if (cnt_r == 3'd4) begin
          cnt_nxt = 3'd0;
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_MUL: begin
        case (cnt_r)
          3'd0:    bm_nxt = mul_p[15:0];
          3'd1:    dm_nxt = mul_p[15:0];
          3'd2:    ae_nxt = mul_p[17:0];
          3'd3: begin
            n0_nxt = mul_p[NW-1:0];
            n1_nxt = NW'({ae_r, 3'd0}) + NW'({ae_r, 1'b0});
          end
          3'd4:    n2_nxt = mul_p[NW-1:0];
          3'd5:    s_nxt = mul_p[SW-1:0];
          3'd6:    s_nxt = s_r + mul_p[SW-1:0];
          default: s_nxt = s_r + mul_p[SW-1:0];
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          comp_nxt = 2'd0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mm_nxt = mul_p[49:0];
        t_nxt = '0;
        bit_nxt = 4'(QW - 1);
        state_nxt = ST_KK;
      end
      ST_KK: begin
        kk_nxt = mul_p[KW-1:0];
        state_nxt = (cand > hngen_pkg::ONE_Q14) ? ST_CMP : ST_PL;
      end
      ST_PL: begin
        pl_nxt = mul_p[55:0];
        state_nxt = ST_PH;
      end
      ST_PH: begin
        ph_nxt = mul_p[55:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if ((cand <= hngen_pkg::ONE_Q14) && (lhs <= rhs)) begin
          t_nxt = cand;
        end
        if (bit_r == 4'd0) begin
          case (comp_r)
            2'd0:    r0_nxt = t_nxt;
            2'd1:    r1_nxt = t_nxt;
            default: r2_nxt = t_nxt;
          endcase
          comp_nxt = comp_r + 2'd1;
          state_nxt = (comp_r == 2'd2) ? ST_OUT : ST_SQ;
        end else begin
          bit_nxt = bit_r - 4'd1;
          state_nxt = ST_KK;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {fz, fy, fx};
          out_user_nxt = err_r ? hngen_pkg::STAT_OOB : hngen_pkg::STAT_OK;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      grid_r <= 8'd128;
      sclx_r <= 8'd1;
      scly_r <= 8'd1;
      sclz_r <= 8'd1;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          hngen_pkg::REG_GRID_SIZE: grid_r <= cfg_wdata;
          hngen_pkg::REG_SCALE_X:   sclx_r <= cfg_wdata;
          hngen_pkg::REG_SCALE_Y:   scly_r <= cfg_wdata;
          hngen_pkg::REG_SCALE_Z:   sclz_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; z_r <= z_nxt; xw_r <= xw_nxt; xe_r <= xe_nxt; zs_r <= zs_nxt;
    zn_r <= zn_nxt; dx2_r <= dx2_nxt; dz2_r <= dz2_nxt; err_r <= err_nxt;
    cnt_r <= cnt_nxt; hw_r <= hw_nxt; he_r <= he_nxt; hs_r <= hs_nxt; hn_r <= hn_nxt;
    bm_r <= bm_nxt; dm_r <= dm_nxt; ae_r <= ae_nxt;
    n0_r <= n0_nxt; n1_r <= n1_nxt; n2_r <= n2_nxt; s_r <= s_nxt; mm_r <= mm_nxt;
    kk_r <= kk_nxt; pl_r <= pl_nxt; ph_r <= ph_nxt; t_r <= t_nxt; bit_r <= bit_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; r2_r <= r2_nxt; comp_r <= comp_nxt;
    out_data_r <= out_data_nxt; out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for heightmap_normal_generator_unit: height writes and
// normal queries over stream ports, exact integer prediction of Q2.14 normals.
// Depends on hngen_pkg and the unit RTL only.
module testbench;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               status;
  } normal_t;

  class normal_scoreboard;
    normal_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note_query(normal_t n);
      pending = {pending, n};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_beat(logic [47:0] data, logic user);
      normal_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat data=%h status=%0d", data, user));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (data[15:0] !== want.nx)
        report($sformatf("normal_x got %0d want %0d", $signed(data[15:0]), want.nx));
      if (data[31:16] !== want.ny)
        report($sformatf("normal_y got %0d want %0d", $signed(data[31:16]), want.ny));
      if (data[47:32] !== want.nz)
        report($sformatf("normal_z got %0d want %0d", $signed(data[47:32]), want.nz));
      if (user !== want.status)
        report($sformatf("status got %0d want %0d", user, want.status));
    endtask
  endclass

  localparam int SIDE_MAX = 128;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;

  heightmap_normal_generator_unit dut (.*);

  normal_scoreboard sb = new();

  logic [7:0] heights [0:SIDE_MAX*SIDE_MAX-1];
  bit         written [0:SIDE_MAX*SIDE_MAX-1];
  logic [7:0] r_grid, r_sx, r_sy, r_sz;
  bit         quiet;
  int         n_items, n_queries, n_oob, n_writes;
  longint     cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);

  always @(negedge clk)
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);

  function automatic int side_now();
    int s;
    s = r_grid;
    if (s < 2) s = 2;
    if (s > SIDE_MAX) s = SIDE_MAX;
    return s;
  endfunction

  function automatic logic [15:0] q14_field(longint v, longint unsigned s);
    longint unsigned m;
    logic [127:0] lhs, rhs, kk;
    int lo, hi, t;
    m = (v < 0) ? -v : v;
    rhs = 128'(m * m) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      t = (lo + hi + 1) >> 1;
      kk = 128'(2 * t - 1);
      lhs = kk * kk * 128'(s);
      if (lhs <= rhs) lo = t;
      else hi = t - 1;
    end
    return (v < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic longint h_at(int x, int z);
    return longint'(heights[z * SIDE_MAX + x]);
  endfunction

  function automatic normal_t predict_normal(int x, int z);
    normal_t r;
    int side, xw, xe, zs, zn;
    longint sx, sy, sz, a, e, b, d, nx, ny, nz;
    longint unsigned mag;
    side = side_now();
    r = '0;
    if (x >= side || z >= side) begin
      r.status = hngen_pkg::STAT_OOB;
      return r;
    end
    sx = r_sx ? r_sx : 1;
    sy = r_sy ? r_sy : 1;
    sz = r_sz ? r_sz : 1;
    xw = x > 0 ? x - 1 : 0;
    xe = x < side - 1 ? x + 1 : x;
    zs = z > 0 ? z - 1 : 0;
    zn = z < side - 1 ? z + 1 : z;
    a = (xe - xw) * sx;
    e = (zn - zs) * sz;
    b = (h_at(xe, z) - h_at(xw, z)) * sy;
    d = (h_at(x, zn) - h_at(x, zs)) * sy;
    nx = -b * e;
    ny = 10 * a * e;
    nz = -a * d;
    mag = nx * nx + ny * ny + nz * nz;
    r.nx = q14_field(nx, mag);
    r.ny = q14_field(ny, mag);
    r.nz = q14_field(nz, mag);
    r.status = hngen_pkg::STAT_OK;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_beat(logic kind, int x, int z, logic [7:0] h);
    int side;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, h, 7'(z), 7'(x)};
    do @(posedge clk); while (!in_tready);
    side = side_now();
    n_items++;
    if (kind == hngen_pkg::REQ_WRITE) begin
      n_writes++;
      if (x < side && z < side) begin
        heights[z * SIDE_MAX + x] = h;
        written[z * SIDE_MAX + x] = 1;
      end
    end else begin
      n_queries++;
      if (x >= side || z >= side) n_oob++;
      sb.note_query(predict_normal(x, z));
    end
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [7:0] pick_height();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic make_ready(int x, int z);
    int side, xs[4], zs[4];
    side = side_now();
    xs = '{x > 0 ? x - 1 : 0, x < side - 1 ? x + 1 : x, x, x};
    zs = '{z, z, z > 0 ? z - 1 : 0, z < side - 1 ? z + 1 : z};
    for (int i = 0; i < 4; i++)
      if (!written[zs[i] * SIDE_MAX + xs[i]])
        send_beat(hngen_pkg::REQ_WRITE, xs[i], zs[i], pick_height());
  endtask

  task automatic query_at(int x, int z);
    if (x < side_now() && z < side_now()) make_ready(x, z);
    send_beat(hngen_pkg::REQ_QUERY, x, z, 8'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      hngen_pkg::REG_GRID_SIZE: r_grid = val;
      hngen_pkg::REG_SCALE_X:   r_sx = val;
      hngen_pkg::REG_SCALE_Y:   r_sy = val;
      default:                  r_sz = val;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(logic [7:0] g, logic [7:0] sx, logic [7:0] sy, logic [7:0] sz);
    drain();
    set_reg(hngen_pkg::REG_GRID_SIZE, g);
    set_reg(hngen_pkg::REG_SCALE_X, sx);
    set_reg(hngen_pkg::REG_SCALE_Y, sy);
    set_reg(hngen_pkg::REG_SCALE_Z, sz);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_coord(int side);
    case ($urandom_range(7))
      0: return 0;
      1: return side - 1;
      2: return $urandom_range(side - 1);
      default: return $urandom_range(side < 10 ? side - 1 : 9);
    endcase
  endfunction

  task automatic random_phase(int actions);
    int side, x, z;
    side = side_now();
    repeat (actions) begin
      case ($urandom_range(19))
        0, 1, 2: send_beat(hngen_pkg::REQ_WRITE, pick_coord(side), pick_coord(side),
                           pick_height());
        3, 4:    send_beat(hngen_pkg::REQ_WRITE, $urandom_range(127), $urandom_range(127),
                           8'($urandom));
        5, 6: begin
          x = $urandom_range(127);
          z = $urandom_range(127);
          if (x < side && z < side && side < SIDE_MAX) x = side + $urandom_range(127 - side);
          query_at(x, z);
        end
        default: query_at(pick_coord(side), pick_coord(side));
      endcase
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = hngen_pkg::REQ_WRITE;
    quiet = 0;
    r_grid = 8'd128;
    r_sx = 8'd1;
    r_sy = 8'd1;
    r_sz = 8'd1;
    foreach (written[i]) written[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // corners, edges and steep slopes at reset settings, then at extreme grid and scale settings
    send_beat(hngen_pkg::REQ_WRITE, 0, 0, 8'd0);
    send_beat(hngen_pkg::REQ_WRITE, 1, 0, 8'd255);
    send_beat(hngen_pkg::REQ_WRITE, 0, 1, 8'd255);
    query_at(0, 0);
    send_beat(hngen_pkg::REQ_WRITE, 127, 127, 8'd255);
    send_beat(hngen_pkg::REQ_WRITE, 126, 127, 8'd0);
    send_beat(hngen_pkg::REQ_WRITE, 127, 126, 8'd0);
    query_at(127, 127);
    query_at(127, 0);
    query_at(64, 64);
    send_beat(hngen_pkg::REQ_QUERY, 0, 0, 8'hff);
    configure(8'd0, 8'd0, 8'd0, 8'd0);
    query_at(1, 1);
    send_beat(hngen_pkg::REQ_QUERY, 2, 1, 8'h00);
    send_beat(hngen_pkg::REQ_WRITE, 127, 2, 8'h5a);
    configure(8'd255, 8'd255, 8'd255, 8'd255);
    query_at(1, 0);
    query_at(0, 1);
    configure(8'd1, 8'd1, 8'd255, 8'd1);
    query_at(0, 0);
    send_beat(hngen_pkg::REQ_QUERY, 1, 127, 8'h00);

    configure(8'd128, 8'd1, 8'd1, 8'd1);
    random_phase(60);
    configure(8'd2, 8'd255, 8'd255, 8'd255);
    random_phase(40);
    configure(8'd16, 8'($urandom), 8'($urandom), 8'($urandom));
    quiet = 1;
    random_phase(60);
    quiet = 0;
    configure(8'd5, 8'd1, 8'd255, 8'd7);
    random_phase(50);
    configure(8'd128, 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(60);
    configure(8'd9, 8'd0, 8'($urandom), 8'd0);
    random_phase(50);
    configure(8'd127, 8'($urandom), 8'd1, 8'($urandom));
    random_phase(50);

    drain();
    repeat (250) @(posedge clk);
    $display("covered %0d beats: %0d writes, %0d queries (%0d outside grid), %0d checked",
             n_items, n_writes, n_queries, n_oob, sb.checked);
    $display("grid sizes 0..255 and scales 0..255 exercised, incl. clamped edges");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== heightmap_normal_generator_unit.f =====
rtl/hngen_pkg.sv
rtl/hngen_ram.sv
rtl/heightmap_normal_generator_unit.sv
tb/sv/testbench.sv
